@@ hdl/ftas_pkg.sv @@
// Shared types and constants of the four-tone additive sine synthesizer.
// No dependencies; imported by ftas_ram users, ftas_scale and the top level.
package ftas_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;

    localparam int NUM_TONES = 4;
    localparam int TONE_W    = 2;
    localparam int STEP_W    = 32;
    localparam int VOL_W     = 7;
    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int ROM_W     = 15;
    localparam int SINE_W    = 16;
    localparam int WEIGHT_W  = 17;
    localparam int PROD_W    = SINE_W + WEIGHT_W;
    localparam int SUM_W     = PROD_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TONE1_STEP    = 3'd0,
        REG_TONE2_STEP    = 3'd1,
        REG_TONE3_STEP    = 3'd2,
        REG_TONE4_STEP    = 3'd3,
        REG_VOLUME        = 3'd4,
        REG_SAMPLE_FORMAT = 3'd5
    } cfg_reg_t;

    localparam logic [STEP_W-1:0] STEP_RESET [NUM_TONES] =
        '{32'd762576, 32'd1400490, 32'd2028666, 32'd2666581};
    localparam logic [VOL_W-1:0] VOLUME_RESET = 7'd75;
    localparam logic             FORMAT_RESET = 1'b1;

    // Q1.15 weights: 1, 8/pi^2, 6/pi^2, 4/pi^2
    localparam logic signed [WEIGHT_W-1:0] TONE_WEIGHT [NUM_TONES] =
        '{17'sd32768, 17'sd26561, 17'sd19921, 17'sd13280};

    typedef struct packed {
        logic             start;
        logic             fmt16;
        logic [VOL_W-1:0] volume;
    } scale_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } scale_status_t;

endpackage

@@ hdl/ftas_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ftas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ftas_scale.sv @@
// Output scaling: volume multiply, divide by 400*2^15 or 400*2^23, round or floor,
// offset and saturate. Depends on ftas_pkg.
module ftas_scale (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ftas_pkg::scale_req_t                req,
    input  logic signed [ftas_pkg::SUM_W-1:0]   sum,
    output ftas_pkg::scale_status_t             status,
    output logic [ftas_pkg::SAMPLE_W-1:0]       result
);
    import ftas_pkg::*;

    localparam int NUM_W       = SUM_W + VOL_W + 1;
    localparam int M_W         = 24;
    localparam int RECIP_W     = 20;
    localparam int DIV16_SHIFT = 19;
    localparam int DIV8_SHIFT  = 27;
    localparam int RECIP_SHIFT = 24;
    localparam int FL_W        = NUM_W - DIV8_SHIFT;
    localparam logic [NUM_W-1:0]   HALF16  = NUM_W'(25) << (DIV16_SHIFT - 1);
    localparam logic signed [FL_W-1:0] OFFSET8 = FL_W'(25 * 128);
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((1 << RECIP_SHIFT) / 25);
    localparam logic [M_W-1:0]     DIVISOR = M_W'(25);

    logic                     vld1_reg, vld2_reg, vld3_reg, done_reg;
    logic                     fmt1_reg, fmt2_reg, fmt3_reg;
    logic                     neg2_reg, neg3_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [M_W-1:0]           m2_reg, m3_reg;
    logic [M_W+RECIP_W-1:0]   prod3_reg;
    logic [SAMPLE_W-1:0]      result_reg;

    logic [NUM_W-1:0]         mag;
    logic signed [FL_W-1:0]   floor8;
    logic [M_W-1:0]           m_next;
    logic [M_W-1:0]           q0;
    logic [M_W-1:0]           rem;
    logic [M_W-1:0]           quot;
    logic [SAMPLE_W-1:0]      result_next;

    always_comb
    begin
        mag    = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        floor8 = FL_W'(num_reg >>> DIV8_SHIFT) + OFFSET8;
        if (fmt1_reg)
        begin
            m_next = M_W'((mag + HALF16) >> DIV16_SHIFT);
        end
        else
        begin
            m_next = M_W'(floor8);
        end
    end

    // Reciprocal estimate is low by at most one; one compare fixes it.
    always_comb
    begin
        q0   = M_W'(prod3_reg >> RECIP_SHIFT);
        rem  = m3_reg - q0 * DIVISOR;
        quot = (rem >= DIVISOR) ? q0 + M_W'(1) : q0;
        if (fmt3_reg)
        begin
            if (neg3_reg)
            begin
                result_next = (quot > M_W'(32768)) ? 16'h8000 : SAMPLE_W'(-quot);
            end
            else
            begin
                result_next = (quot > M_W'(32767)) ? 16'h7FFF : SAMPLE_W'(quot);
            end
        end
        else
        begin
            result_next = (quot > M_W'(255)) ? 16'h00FF : {8'h00, quot[7:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= req.start;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            done_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= sum * $signed({1'b0, req.volume});
            fmt1_reg <= req.fmt16;
        end
        m2_reg    <= m_next;
        neg2_reg  <= num_reg[NUM_W-1];
        fmt2_reg  <= fmt1_reg;
        prod3_reg <= m2_reg * RECIP;
        m3_reg    <= m2_reg;
        neg3_reg  <= neg2_reg;
        fmt3_reg  <= fmt2_reg;
        if (vld3_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign status.busy = vld1_reg | vld2_reg | vld3_reg | done_reg;
    assign status.done = done_reg;
    assign result      = result_reg;

endmodule

@@ hdl/four_tone_additive_sine_synth.sv @@
// Top level of the four-tone additive sine synthesizer.
// Depends on ftas_pkg, ftas_ram and ftas_scale.

// One input beat (restart flag) yields one output beat (sample). Four phase
// accumulators live in a small RAM; per beat the sequencer reads each phase,
// looks up the quarter-wave sine, writes the advanced phase back and
// accumulates the weighted sine through one shared multiplier, one tone per
// cycle. The scaling pipeline then applies volume and format. A beat passes
// from acceptance to the scaling launch through the four serial phase reads
// and the three-stage tone pipeline, and the scaling pipeline then produces
// the sample. The next beat is accepted only once the sequencer is back in
// idle. The output register holds a finished sample while the next beat is
// already at work. Phases reset to zero through per-entry valid bits, and a
// restart beat clears those bits, so no clearing pass is needed.
// Configuration writes are always ready.
module four_tone_additive_sine_synth #(
    parameter int PHASE_BITS      = ftas_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = ftas_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ftas_pkg::SAMPLE_W-1:0] sample,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ftas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ftas_pkg::STEP_W-1:0]       cfg_data
);
    import ftas_pkg::*;

    localparam int QUARTER_BITS = TABLE_ADDR_BITS - 2;
    localparam int QUARTER_SIZE = 1 << QUARTER_BITS;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [ROM_W-1:0] rom_t [QUARTER_SIZE];

    // Quarter entry k: sin(pi/2*(2k+1)/(2Q)) by a nested Taylor series in Q30.
    function automatic logic [63:0] quarter_sine(input logic [63:0] k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = ((64'd2 * k + 64'd1) * HALF_PI_Q30) >> (QUARTER_BITS + 1);
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - (((x2 * t) >> 30) / 110);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 72);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 42);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 20);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 6);
        s  = (x * t) >> 30;
        s  = (s + (64'd1 << 14)) >> 15;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return s;
    endfunction

    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] v;
        for (int k = 0; k < QUARTER_SIZE; k++)
        begin
            v    = quarter_sine(64'(k));
            r[k] = v[ROM_W-1:0];
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_SCALE
    } state_t;

    // Configuration registers
    logic [STEP_W-1:0] step_reg [NUM_TONES];
    logic [VOL_W-1:0]  volume_reg;
    logic              format_reg;

    // Sequencer
    state_t            state_reg;
    logic [TONE_W:0]   rd_cnt_reg;
    logic              out_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [NUM_TONES-1:0] phase_valid_reg;

    // Tone pipeline
    logic                       s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [TONE_W-1:0]          s1_tone_reg, s2_tone_reg, s3_tone_reg;
    logic                       s2_neg_reg;
    logic [ROM_W-1:0]           rom_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    acc_reg;

    logic                       accept;
    logic                       ram_re;
    logic [PHASE_BITS-1:0]      ram_rdata;
    logic [PHASE_BITS-1:0]      cur_phase;
    logic [PHASE_BITS-1:0]      phase_next;
    logic [TABLE_ADDR_BITS-1:0] tab_addr;
    logic [1:0]                 quad;
    logic [QUARTER_BITS-1:0]    rom_idx;
    logic signed [SINE_W-1:0]   sine_val;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [SUM_W-1:0]    acc_next;
    logic                       last_acc;
    logic                       out_take;
    logic                       scale_go;
    scale_req_t                 scl_req;
    scale_status_t              scl_status;
    logic [SAMPLE_W-1:0]        scl_result;

    assign accept    = in_valid & ~in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_take  = out_valid_reg & ~out_stall;
    assign cfg_ready = 1'b1;
    assign ram_re    = (state_reg == ST_RUN) && (rd_cnt_reg < (TONE_W+1)'(NUM_TONES));
    assign last_acc  = s3_vld_reg && (s3_tone_reg == TONE_W'(NUM_TONES - 1));

    // Launch scaling only when the output register is empty by the next edge.
    assign scale_go  = (state_reg == ST_SCALE) && !scl_status.busy &&
                       (!out_valid_reg || !out_stall);

    // Configuration writes; indexes beyond the list drop silently.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TONES; i++)
            begin
                step_reg[i] <= STEP_RESET[i];
            end
            volume_reg <= VOLUME_RESET;
            format_reg <= FORMAT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TONE1_STEP:    step_reg[0] <= cfg_data;
                REG_TONE2_STEP:    step_reg[1] <= cfg_data;
                REG_TONE3_STEP:    step_reg[2] <= cfg_data;
                REG_TONE4_STEP:    step_reg[3] <= cfg_data;
                REG_VOLUME:        volume_reg  <= cfg_data[VOL_W-1:0];
                REG_SAMPLE_FORMAT: format_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        rd_cnt_reg <= '0;
                        state_reg  <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (ram_re)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + (TONE_W+1)'(1);
                    end
                    if (last_acc)
                    begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    if (scale_go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (scl_status.done)
            begin
                out_valid_reg <= 1'b1;
                sample_reg    <= scl_result;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Phase memory: one entry per tone. Tones are visited in order and each
    // entry is written back before the next beat reads it, so no forwarding.
    ftas_ram #(
        .WIDTH (PHASE_BITS),
        .DEPTH (NUM_TONES)
    ) u_phase_ram (
        .clk   (clk),
        .we    (s1_vld_reg),
        .waddr (s1_tone_reg),
        .wdata (phase_next),
        .re    (ram_re),
        .raddr (rd_cnt_reg[TONE_W-1:0]),
        .rdata (ram_rdata)
    );

    // Stage 1: pick the phase (zero if never written since reset or restart),
    // advance it, and fold the table address into the quarter wave.
    always_comb
    begin
        cur_phase  = phase_valid_reg[s1_tone_reg] ? ram_rdata : '0;
        phase_next = cur_phase + PHASE_BITS'(step_reg[s1_tone_reg]);
        tab_addr   = cur_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
        quad       = tab_addr[TABLE_ADDR_BITS-1 -: 2];
        rom_idx    = quad[0] ? ~tab_addr[QUARTER_BITS-1:0] : tab_addr[QUARTER_BITS-1:0];
    end

    // Stage 2: restore sign and weight; stage 3: accumulate in Q30.
    always_comb
    begin
        sine_val  = s2_neg_reg ? -$signed({1'b0, rom_reg}) : $signed({1'b0, rom_reg});
        prod_next = sine_val * TONE_WEIGHT[s2_tone_reg];
        acc_next  = acc_reg + {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_valid_reg <= '0;
            s1_vld_reg      <= 1'b0;
            s2_vld_reg      <= 1'b0;
            s3_vld_reg      <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= ram_re;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            if (accept && restart)
            begin
                phase_valid_reg <= '0;
            end
            else if (s1_vld_reg)
            begin
                phase_valid_reg[s1_tone_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tone_reg <= rd_cnt_reg[TONE_W-1:0];
        s2_tone_reg <= s1_tone_reg;
        s3_tone_reg <= s2_tone_reg;
        s2_neg_reg  <= quad[1];
        rom_reg     <= SINE_ROM[rom_idx];
        prod_reg    <= prod_next;
        if (accept)
        begin
            acc_reg <= '0;
        end
        else if (s3_vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign scl_req.start  = scale_go;
    assign scl_req.fmt16  = format_reg;
    assign scl_req.volume = volume_reg;

    ftas_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (scl_req),
        .sum    (acc_reg),
        .status (scl_status),
        .result (scl_result)
    );

    assign out_valid = out_valid_reg;
    assign sample    = $signed(sample_reg);

endmodule
